### hw/rtl/knhf_pkg.sv
// ----------------------------------------------------------------------------
// Key note detector package
// Shared types and constants for the key note on/off hysteresis detector.
// ----------------------------------------------------------------------------
package knhf_pkg;

    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned VEL_W      = 7;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DEBOUNCE_W = 16;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [VEL_W:0]      DEAD_MARGIN = 8'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_ON  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_OFF = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BASELINE      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_MS   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_NOTE      = 3'd4;

    localparam logic [VEL_W-1:0]      RST_THRESHOLD_ON  = 7'd100;
    localparam logic [VEL_W-1:0]      RST_THRESHOLD_OFF = 7'd20;
    localparam logic [VEL_W-1:0]      RST_BASELINE      = 7'd0;
    localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE_MS   = 16'd50;
    localparam logic [VEL_W-1:0]      RST_KEY_NOTE      = 7'd60;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_ON   = 2'd1,
        ST_OFF  = 2'd2
    } t_state;

    typedef struct packed {
        logic [VEL_W-1:0]  vel;
        logic [TIME_W-1:0] now_ms;
        logic              above_on;
        logic              below_off;
        logic              dead;
    } t_item;

endpackage

### hw/rtl/knhf_front.sv
// ----------------------------------------------------------------------------
// Key note detector front end
// Scales a sample to a velocity and classifies it against the thresholds.
// ----------------------------------------------------------------------------
module knhf_front
    import knhf_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_adc_sample,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic [VEL_W-1:0]    i_threshold_on,
    input  logic [VEL_W-1:0]    i_threshold_off,
    input  logic [VEL_W-1:0]    i_baseline,
    output t_item               o_item
);

    logic [SAMPLE_W+VEL_W-1:0] w_product;
    logic [VEL_W-1:0]          w_quot;
    logic [SAMPLE_W:0]         w_rem;
    logic [VEL_W-1:0]          w_vel;

    // Division by 4095 uses 4096 = 4095 + 1: the remainder estimate stays
    // below twice the divisor, so one correction step is enough.
    assign w_product = ({i_adc_sample, 7'd0}) - {7'd0, i_adc_sample};
    assign w_quot    = w_product[SAMPLE_W+VEL_W-1:SAMPLE_W];
    assign w_rem     = {1'b0, w_product[SAMPLE_W-1:0]} + {6'd0, w_quot};
    assign w_vel     = (w_rem >= {1'b0, FULL_SCALE}) ? w_quot + 7'd1 : w_quot;

    always_comb begin
        o_item.vel       = w_vel;
        o_item.now_ms    = i_now_ms;
        o_item.above_on  = w_vel > i_threshold_on;
        o_item.below_off = w_vel < i_threshold_off;
        o_item.dead      = ({1'b0, w_vel} + DEAD_MARGIN) < {1'b0, i_baseline};
    end

endmodule

### hw/rtl/knhf_queue.sv
// ----------------------------------------------------------------------------
// Key note detector queue
// Two-entry queue between the front end and the state machine.
// ----------------------------------------------------------------------------
module knhf_queue
    import knhf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("queue read while empty");

endmodule

### hw/rtl/knhf_back.sv
// ----------------------------------------------------------------------------
// Key note detector back end
// Runs the note state machine and holds the result in an output register.
// ----------------------------------------------------------------------------
module knhf_back
    import knhf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_item                 i_q_item,
    output logic                  o_q_pop,
    input  logic [DEBOUNCE_W-1:0] i_debounce_ms,
    input  logic [VEL_W-1:0]      i_key_note,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_midi_ready,
    output logic                  o_note_status,
    output logic [VEL_W-1:0]      o_note_velocity,
    output logic [VEL_W-1:0]      o_note_number
);

    t_state            r_state;
    t_state            n_state;
    logic              r_sounding;
    logic              n_sounding;
    logic              r_ready_flag;
    logic              n_ready_flag;
    logic [VEL_W-1:0]  r_held_vel;
    logic [VEL_W-1:0]  n_held_vel;
    logic              r_held_status;
    logic              n_held_status;
    logic [TIME_W-1:0] r_on_time;
    logic [TIME_W-1:0] n_on_time;
    logic              r_out_valid;
    logic              r_out_ready;
    logic              r_out_status;
    logic [VEL_W-1:0]  r_out_vel;
    logic [VEL_W-1:0]  r_out_note;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_timed_out;
    logic              w_advance;

    assign w_advance   = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop     = w_advance;
    assign w_elapsed   = i_q_item.now_ms - r_on_time;
    assign w_timed_out = w_elapsed > {16'd0, i_debounce_ms};

    always_comb begin
        n_state       = r_state;
        n_sounding    = r_sounding;
        n_ready_flag  = r_ready_flag;
        n_held_vel    = r_held_vel;
        n_held_status = r_held_status;
        n_on_time     = r_on_time;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_item.above_on && !r_sounding && !r_ready_flag) begin
                    n_held_vel    = i_q_item.vel;
                    n_held_status = 1'b1;
                    n_sounding    = 1'b1;
                    n_ready_flag  = 1'b1;
                    n_on_time     = i_q_item.now_ms;
                    n_state       = ST_ON;
                end else begin
                    n_ready_flag = 1'b0;
                end
            end
            ST_ON: begin
                if (r_sounding && !r_ready_flag &&
                    (i_q_item.below_off || (i_q_item.dead && w_timed_out))) begin
                    n_held_vel    = '0;
                    n_held_status = 1'b0;
                    n_sounding    = 1'b0;
                    n_ready_flag  = 1'b1;
                    n_state       = ST_OFF;
                end else begin
                    n_ready_flag = 1'b0;
                end
            end
            default: begin
                n_ready_flag = 1'b0;
                n_state      = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_sounding    <= 1'b0;
            r_ready_flag  <= 1'b0;
            r_held_vel    <= '0;
            r_held_status <= 1'b0;
            r_on_time     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_advance) begin
                r_state       <= n_state;
                r_sounding    <= n_sounding;
                r_ready_flag  <= n_ready_flag;
                r_held_vel    <= n_held_vel;
                r_held_status <= n_held_status;
                r_on_time     <= n_on_time;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_ready  <= n_ready_flag;
            r_out_status <= n_held_status;
            r_out_vel    <= n_held_vel;
            r_out_note   <= i_key_note;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_midi_ready    = r_out_ready;
    assign o_note_status   = r_out_status;
    assign o_note_velocity = r_out_vel;
    assign o_note_number   = r_out_note;

    a_sounding_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sounding == (r_state == ST_ON))
        else $error("sounding flag disagrees with state");

    a_status_sounding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_status == r_sounding)
        else $error("held status disagrees with sounding flag");

    a_off_velocity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sounding |-> (r_held_vel == '0))
        else $error("velocity held while no note sounds");

    a_idle_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_ready_flag)
        else $error("ready flag set in idle");

endmodule

### hw/rtl/key_note_on_off_hysteresis_fsm.sv
// A sample passes through the queue and the output register to the result.
// One sample per cycle if not stalled; back end takes one queue entry a cycle.
// A stalled output fills the two-entry queue, after which input ready drops.
// Reset is synchronous and active low; it clears the state machine, the queue
// and the output valid flag, and loads the register defaults.
// ----------------------------------------------------------------------------
// Key note on/off hysteresis detector
// Turns key sensor samples into note on and note off events with hysteresis.
// ----------------------------------------------------------------------------
module key_note_on_off_hysteresis_fsm
    import knhf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SAMPLE_W-1:0]   i_adc_sample,
    input  logic [TIME_W-1:0]     i_now_ms,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_midi_ready,
    output logic                  o_note_status,
    output logic [VEL_W-1:0]      o_note_velocity,
    output logic [VEL_W-1:0]      o_note_number,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [VEL_W-1:0]      r_threshold_on;
    logic [VEL_W-1:0]      r_threshold_off;
    logic [VEL_W-1:0]      r_baseline;
    logic [DEBOUNCE_W-1:0] r_debounce_ms;
    logic [VEL_W-1:0]      r_key_note;
    t_item                 w_front_item;
    t_item                 w_q_item;
    logic                  w_q_full;
    logic                  w_q_valid;
    logic                  w_q_pop;
    logic                  w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold_on  <= RST_THRESHOLD_ON;
            r_threshold_off <= RST_THRESHOLD_OFF;
            r_baseline      <= RST_BASELINE;
            r_debounce_ms   <= RST_DEBOUNCE_MS;
            r_key_note      <= RST_KEY_NOTE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_THRESHOLD_ON:  r_threshold_on  <= i_cfg_data[VEL_W-1:0];
                REG_THRESHOLD_OFF: r_threshold_off <= i_cfg_data[VEL_W-1:0];
                REG_BASELINE:      r_baseline      <= i_cfg_data[VEL_W-1:0];
                REG_DEBOUNCE_MS:   r_debounce_ms   <= i_cfg_data[DEBOUNCE_W-1:0];
                REG_KEY_NOTE:      r_key_note      <= i_cfg_data[VEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_ready = !w_q_full;
    assign w_push  = i_valid && !w_q_full;

    knhf_front u_front (
        .i_adc_sample    (i_adc_sample),
        .i_now_ms        (i_now_ms),
        .i_threshold_on  (r_threshold_on),
        .i_threshold_off (r_threshold_off),
        .i_baseline      (r_baseline),
        .o_item          (w_front_item)
    );

    knhf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    knhf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_pop         (w_q_pop),
        .i_debounce_ms   (r_debounce_ms),
        .i_key_note      (r_key_note),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_midi_ready    (o_midi_ready),
        .o_note_status   (o_note_status),
        .o_note_velocity (o_note_velocity),
        .o_note_number   (o_note_number)
    );

endmodule
